/* design/sle_pkg.sv */
// Shared types, constants and result decoding for the serial line editor.
package sle_pkg;

    // Line buffer and capacity limits
    localparam int BUFFER_DEPTH = 256;
    localparam int CAP_LIMIT    = (BUFFER_DEPTH < 256) ? BUFFER_DEPTH : 256;
    localparam int CAP_W        = 9;
    localparam int BYTE_W       = 8;
    localparam int ADDR_W       = 8;
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(CAP_LIMIT);
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Item kinds and terminal keys
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_ARM  = 1'b1;
    localparam logic [BYTE_W-1:0] KEY_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] KEY_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] KEY_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] KEY_DEL   = 8'd127;
    localparam logic [BYTE_W-1:0] KEY_SPACE = 8'd32;

    typedef enum logic [1:0] {
        OP_ARM,
        OP_CR,
        OP_BS,
        OP_STORE
    } op_t;

    typedef logic [1:0] step_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              line_ready;
    } cmd_t;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] echo_byte;
        logic              wr_valid;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              line_ready;
        logic              last;
    } result_t;

    // Decode one result word of a command at a given step
    function automatic result_t make_result(cmd_t cmd, step_t step);
        result_t r;
        r            = '0;
        r.line_ready = cmd.line_ready;
        unique case (cmd.op)
            OP_ARM:
            begin
                r.wr_valid = 1'b1;
                r.last     = 1'b1;
            end
            OP_CR:
            begin
                r.tx_valid  = 1'b1;
                r.echo_byte = (step == 2'd0) ? KEY_CR : KEY_LF;
                r.last      = (step != 2'd0);
            end
            OP_BS:
            begin
                r.tx_valid = 1'b1;
                if (step == 2'd0)
                begin
                    r.echo_byte = KEY_BS;
                    r.wr_valid  = 1'b1;
                    r.wr_addr   = cmd.addr;
                end
                else if (step == 2'd1)
                begin
                    r.echo_byte = KEY_SPACE;
                end
                else
                begin
                    r.echo_byte = KEY_BS;
                    r.last      = 1'b1;
                end
            end
            OP_STORE:
            begin
                r.wr_valid = 1'b1;
                if (step == 2'd0)
                begin
                    r.tx_valid  = 1'b1;
                    r.echo_byte = cmd.data;
                    r.wr_addr   = cmd.addr;
                    r.wr_data   = cmd.data;
                end
                else
                begin
                    r.wr_addr = cmd.addr + ADDR_W'(1);
                    r.last    = 1'b1;
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

/* design/sle_front.sv */
// Front end: accepts words, tracks line state and classifies into commands.
module sle_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [sle_pkg::CAP_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [sle_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                        q_full,
    output logic                        q_push,
    output sle_pkg::cmd_t               q_cmd
);
    import sle_pkg::*;

    logic [CAP_W-1:0]  capacity_reg;
    logic              editing_reg;
    logic              editing_next;
    logic [ADDR_W-1:0] cursor_reg;
    logic [ADDR_W-1:0] cursor_next;
    logic [CAP_W-1:0]  cap_eff;
    logic [CAP_W-1:0]  cursor_inc;
    logic              accept;
    logic              produce;
    op_t               op;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // Limit the capacity to the buffer and address range
    assign cap_eff    = (capacity_reg > CAP_MAX) ? CAP_MAX : capacity_reg;
    assign cursor_inc = {1'b0, cursor_reg} + CAP_W'(1);

    // Classify the word and work out the next line state
    always_comb
    begin
        editing_next = editing_reg;
        cursor_next  = cursor_reg;
        produce      = 1'b0;
        op           = OP_ARM;
        priority if (kind == KIND_ARM)
        begin
            editing_next = 1'b1;
            cursor_next  = '0;
            produce      = 1'b1;
            op           = OP_ARM;
        end
        else if (!editing_reg)
        begin
            produce = 1'b0;
        end
        else if (rx_byte == KEY_CR)
        begin
            editing_next = 1'b0;
            produce      = 1'b1;
            op           = OP_CR;
        end
        else if (rx_byte == KEY_DEL)
        begin
            if (cursor_reg != '0)
            begin
                cursor_next = cursor_reg - ADDR_W'(1);
                produce     = 1'b1;
                op          = OP_BS;
            end
        end
        else if (cursor_inc < cap_eff)
        begin
            cursor_next = cursor_inc[ADDR_W-1:0];
            produce     = 1'b1;
            op          = OP_STORE;
        end
        else
        begin
            // drop a byte with no room left
            produce = 1'b0;
        end
    end

    assign q_push = accept && produce;

    // Build the command word
    always_comb
    begin
        q_cmd.op         = op;
        q_cmd.addr       = (op == OP_BS) ? cursor_next : cursor_reg;
        q_cmd.data       = rx_byte;
        q_cmd.line_ready = !editing_next;
    end

    // Hold configuration and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            editing_reg  <= 1'b0;
            cursor_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                editing_reg <= editing_next;
                cursor_reg  <= cursor_next;
            end
        end
    end

endmodule

/* design/sle_queue.sv */
// Short command queue between the front and back ends.
module sle_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sle_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output sle_pkg::cmd_t head
);
    import sle_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* design/sle_back.sv */
// Back end: expands each command into its result words, one per cycle while the output is not stalled.
module sle_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_not_empty,
    input  sle_pkg::cmd_t               q_head,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        tx_valid,
    output logic [sle_pkg::BYTE_W-1:0]  echo_byte,
    output logic                        wr_valid,
    output logic [sle_pkg::ADDR_W-1:0]  wr_addr,
    output logic [sle_pkg::BYTE_W-1:0]  wr_data,
    output logic                        line_ready,
    output logic                        last
);
    import sle_pkg::*;

    step_t   step_reg;
    step_t   step_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res;
    result_t res_reg;
    logic    load;

    assign res   = make_result(q_head, step_reg);
    assign load  = q_not_empty && (!out_valid_reg || !out_stall);
    assign q_pop = load && res.last;

    // Step through the command's words
    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            step_next      = res.last ? step_t'(0) : step_reg + step_t'(1);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output word until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tx_valid   = res_reg.tx_valid;
    assign echo_byte  = res_reg.echo_byte;
    assign wr_valid   = res_reg.wr_valid;
    assign wr_addr    = res_reg.wr_addr;
    assign wr_data    = res_reg.wr_data;
    assign line_ready = res_reg.line_ready;
    assign last       = res_reg.last;

endmodule

/* design/serial_line_editor_top.sv */
// Top level of the serial line editor with terminal echo.
// Each received word (a byte or an arm request) is accepted while the four-entry
// command queue has room, so words may arrive back to back. The back end emits one
// result word per cycle from the queue head while the output is not stalled: an arm
// gives one word, a carriage return or a stored byte two, a backspace three, and
// ignored bytes none. Sustained throughput is therefore set by the number of result
// words the back end sends through its single output register. The capacity
// register may be written at any cycle and takes effect for the next accepted word.
module serial_line_editor_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [sle_pkg::CAP_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [sle_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        tx_valid,
    output logic [sle_pkg::BYTE_W-1:0]  echo_byte,
    output logic                        wr_valid,
    output logic [sle_pkg::ADDR_W-1:0]  wr_addr,
    output logic [sle_pkg::BYTE_W-1:0]  wr_data,
    output logic                        line_ready,
    output logic                        last
);
    import sle_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_cmd;
    cmd_t q_head;

    sle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .rx_byte     (rx_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    sle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    sle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_valid    (tx_valid),
        .echo_byte   (echo_byte),
        .wr_valid    (wr_valid),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .line_ready  (line_ready),
        .last        (last)
    );

endmodule

/* design/sle_checker.sv */
// Port-level checks for the serial line editor, bound to the top level.
module sle_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        tx_valid,
    input logic [sle_pkg::BYTE_W-1:0]  echo_byte,
    input logic                        wr_valid,
    input logic [sle_pkg::ADDR_W-1:0]  wr_addr,
    input logic [sle_pkg::BYTE_W-1:0]  wr_data
);
    import sle_pkg::*;

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(echo_byte) && $stable(wr_addr))
        else $error("stalled output word changed");

    // Every output word carries an echo or a write
    a_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tx_valid || wr_valid)
        else $error("output word with neither echo nor write");

    // Unused echo field reads zero
    a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> echo_byte == '0)
        else $error("echo byte set without echo");

    // Unused write fields read zero
    a_wr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !wr_valid |-> wr_addr == '0 && wr_data == '0)
        else $error("write fields set without write");

    // A write paired with an echo stores the echoed byte or a terminator
    a_wr_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_valid && wr_valid |-> wr_data == echo_byte || wr_data == '0)
        else $error("write data does not match echo");

endmodule

bind serial_line_editor_top sle_checker u_sle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_valid  (tx_valid),
    .echo_byte (echo_byte),
    .wr_valid  (wr_valid),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
);
